// File: rtl/core/bmpab_pkg.sv
// bmpab_pkg: shared types, register indexes and blend helpers for the bitmap alpha blender
`default_nettype none
package bmpab_pkg;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// field widths fixed by the interface
	localparam int COORD_W    = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int TDATA_W    = 48;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_WIDTH     = 3'd2,
		REG_HEIGHT    = 3'd3,
		REG_SWAP      = 3'd4
	} reg_idx_t;

	// one classified pixel waiting for the blend unit
	typedef struct packed {
		logic [7:0]         src_r;
		logic [7:0]         src_g;
		logic [7:0]         src_b;
		logic [7:0]         dst_r;
		logic [7:0]         dst_g;
		logic [7:0]         dst_b;
		logic [7:0]         alpha;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic               last;
	} job_t;

	// s*a + d*(255-a), at most 255*255
	function automatic logic [15:0] blend_sum(input logic [7:0] s, input logic [7:0] d,
	                                          input logic [7:0] a);
		logic [15:0] ps;
		logic [15:0] pd;
		ps = {8'd0, s} * {8'd0, a};
		pd = {8'd0, d} * {8'd0, 8'd255 - a};
		return ps + pd;
	endfunction

	// exact floor(v/255) for any v up to 255*255, the largest sum that blend_sum gives
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] sum;
		sum = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
		return sum[15:8];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/bmpab_front.sv
// bmpab_front: configuration registers, pixel placement counters and source/destination unpacking
`default_nettype none
module bmpab_front #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration writes
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bmpab_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bmpab_pkg::CFG_DATA_W-1:0]     cfg_data,
	// incoming pixels
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [bmpab_pkg::TDATA_W-1:0]        in_data,
	// towards the queue
	output logic                                      push,
	output bmpab_pkg::job_t                           push_data,
	input  wire logic                                 queue_full
);

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic signed [12:0] origin_x_q;
	logic signed [12:0] origin_y_q;
	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic               swap_q;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] wm1;
	logic [CNT_W-1:0] hm1;
	logic             row_end;
	logic             last;

	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [7:0]  alpha;
	logic [15:0] dc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !queue_full;
	assign push      = in_valid && !queue_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= 13'd1;
			height_q   <= 13'd1;
			swap_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bmpab_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				bmpab_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				bmpab_pkg::REG_WIDTH:    width_q    <= cfg_data;
				bmpab_pkg::REG_HEIGHT:   height_q   <= cfg_data;
				bmpab_pkg::REG_SWAP:     swap_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped sizes minus one
	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (32'(width_q) > MAX_DIM) begin
			wm1 = CNT_W'(MAX_DIM - 1);
		end else begin
			wm1 = CNT_W'(width_q - 13'd1);
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (32'(height_q) > MAX_DIM) begin
			hm1 = CNT_W'(MAX_DIM - 1);
		end else begin
			hm1 = CNT_W'(height_q - 13'd1);
		end
	end

	assign row_end = (col_q >= wm1);
	assign last    = row_end && (row_q >= hm1);

	// placement counters, rows go bottom-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// unpack the input transfer
	assign b0    = in_data[7:0];
	assign b1    = in_data[15:8];
	assign b2    = in_data[23:16];
	assign alpha = in_data[31:24];
	assign dc    = in_data[47:32];

	// classify: channel order, widened destination, coordinates
	always_comb begin
		push_data.src_r = swap_q ? b0 : b2;
		push_data.src_g = b1;
		push_data.src_b = swap_q ? b2 : b0;
		push_data.dst_r = {dc[15:11], 3'b000};
		push_data.dst_g = {dc[10:5], 2'b00};
		push_data.dst_b = {dc[4:0], 3'b000};
		push_data.alpha = alpha;
		push_data.px    = bmpab_pkg::COORD_W'(origin_x_q) + bmpab_pkg::COORD_W'(col_q);
		push_data.py    = bmpab_pkg::COORD_W'(origin_y_q) + bmpab_pkg::COORD_W'(hm1)
		                  - bmpab_pkg::COORD_W'(row_q);
		push_data.last  = last;
	end

endmodule
`default_nettype wire

// File: rtl/core/bmpab_queue.sv
// bmpab_queue: short first-in first-out queue of classified pixels between front and back
`default_nettype none
module bmpab_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  bmpab_pkg::job_t      wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output bmpab_pkg::job_t      rd_data,
	output logic                 not_empty
);

	bmpab_pkg::job_t                   entry_q [bmpab_pkg::QUEUE_DEPTH];
	logic [bmpab_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bmpab_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bmpab_pkg::QCNT_W-1:0]      count_q;

	assign full      = (count_q == bmpab_pkg::QCNT_W'(bmpab_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/bmpab_back.sv
// bmpab_back: two-stage blend pipeline, products then divide by 255 and RGB565 packing
`default_nettype none
module bmpab_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// from the queue
	input  wire logic                              job_valid,
	output logic                                   job_ready,
	input  bmpab_pkg::job_t                        job_data,
	// result stream
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [bmpab_pkg::TDATA_W-1:0]          out_data,
	output logic                                   out_last
);

	logic                               v_s1;
	logic [15:0]                        sum_r_s1;
	logic [15:0]                        sum_g_s1;
	logic [15:0]                        sum_b_s1;
	logic [bmpab_pkg::COORD_W-1:0]      px_s1;
	logic [bmpab_pkg::COORD_W-1:0]      py_s1;
	logic                               last_s1;

	logic                               v_s2;
	logic [bmpab_pkg::TDATA_W-1:0]      data_s2;
	logic                               last_s2;

	logic        ready_s2;
	logic [7:0]  r;
	logic [7:0]  g;
	logic [7:0]  b;
	logic [15:0] color;

	assign ready_s2  = !v_s2 || out_ready;
	assign job_ready = !v_s1 || ready_s2;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (job_ready) begin
				v_s1 <= job_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage one: weighted sums per channel
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			sum_r_s1 <= bmpab_pkg::blend_sum(job_data.src_r, job_data.dst_r, job_data.alpha);
			sum_g_s1 <= bmpab_pkg::blend_sum(job_data.src_g, job_data.dst_g, job_data.alpha);
			sum_b_s1 <= bmpab_pkg::blend_sum(job_data.src_b, job_data.dst_b, job_data.alpha);
			px_s1    <= job_data.px;
			py_s1    <= job_data.py;
			last_s1  <= job_data.last;
		end
	end

	// divide by 255 and pack to RGB565
	assign r     = bmpab_pkg::div255(sum_r_s1);
	assign g     = bmpab_pkg::div255(sum_g_s1);
	assign b     = bmpab_pkg::div255(sum_b_s1);
	assign color = {r[7:3], g[7:2], b[7:3]};

	// stage two: output register
	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			data_s2 <= {4'd0, color, py_s1, px_s1};
			last_s2 <= last_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;
	assign out_last  = last_s2;

endmodule
`default_nettype wire

// File: rtl/core/bmp_alpha_blend_rgb565.sv
// bmp_alpha_blend_rgb565: top level, ARGB8888 over RGB565 blender with bottom-up pixel placement
// an input transfer passes through the queue, the stage-one sums and the output register to m_tdata
// throughput: one pixel per cycle while m_tready stays high; a 4-entry queue decouples placement
// from blending; the blend unit is a two-stage pipeline: products, then divide by 255 into the output register
// reset: counters and pipeline cleared, origin 0, width and height 1, no channel swap
// configuration writes are taken every cycle (cfg_ready is always high)
`default_nettype none
module bmp_alpha_blend_rgb565 #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bmpab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bmpab_pkg::CFG_DATA_W-1:0]   cfg_data,
	// source pixels
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [bmpab_pkg::TDATA_W-1:0]      s_tdata,  // byte_zero, byte_one, byte_two, alpha, dest_color
	// blended pixels
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [bmpab_pkg::TDATA_W-1:0]           m_tdata,  // pixel_x, pixel_y, blended_color, zero pad
	output logic                                    m_tlast
);

	logic            push;
	bmpab_pkg::job_t push_data;
	logic            queue_full;
	logic            queue_not_empty;
	logic            job_ready;
	bmpab_pkg::job_t job_data;

	// placement and classification
	bmpab_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	// decoupling queue
	bmpab_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   (push_data),
		.full      (queue_full),
		.rd_en     (queue_not_empty && job_ready),
		.rd_data   (job_data),
		.not_empty (queue_not_empty)
	);

	// blend pipeline
	bmpab_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_not_empty),
		.job_ready (job_ready),
		.job_data  (job_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

// File: tb/bmp_alpha_blend_rgb565_tb.sv
// testbench for the bitmap alpha blender: random and directed pixels checked against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module bmp_alpha_blend_rgb565_tb;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 37;
	localparam int ITEM_TARGET = 1250;

	// one source pixel as offered on the slave side
	typedef struct packed {
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  alpha;
		logic [15:0] dest;
	} src_pixel_t;

	// one placed and blended pixel as seen on the master side
	typedef struct packed {
		logic [bmpab_pkg::COORD_W-1:0] x;
		logic [bmpab_pkg::COORD_W-1:0] y;
		logic [15:0]                   colour;
		logic                          last;
	} placed_pixel_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [bmpab_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bmpab_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	// byte_zero, byte_one, byte_two, alpha, dest_color
	logic [bmpab_pkg::TDATA_W-1:0]    s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	// pixel_x, pixel_y, blended_color, zero pad
	logic [bmpab_pkg::TDATA_W-1:0]    m_tdata;
	logic                             m_tlast;

	bmp_alpha_blend_rgb565 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and the placement counters
	logic signed [12:0] pred_origin_x = '0;
	logic signed [12:0] pred_origin_y = '0;
	logic [12:0]        pred_width = 13'd1;
	logic [12:0]        pred_height = 13'd1;
	logic               pred_swap = 1'b0;
	int                 column_count = 0;
	int                 row_count = 0;

	src_pixel_t    pending_pixels[$];
	placed_pixel_t expected_pixels[$];
	src_pixel_t    offered_pixel;

	bit no_idle = 1'b0;
	int stall_requests = 0;
	int stall_served = 0;
	int hold_left = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	bit src_take;
	bit src_offer;
	placed_pixel_t seen;

	function automatic int clamp_dim(input logic [12:0] v);
		if (v == 13'd0)
			return 1;
		if (v > 13'd4096)
			return 4096;
		return int'(v);
	endfunction

	function automatic logic [7:0] blend_channel(input int s, input int d, input int a);
		int r;
		r = (s * a + d * (255 - a)) / 255;
		return r[7:0];
	endfunction

	// blend against the destination and place at the current counters, then advance them
	function automatic placed_pixel_t blend_and_place(input src_pixel_t p);
		placed_pixel_t res;
		int w, h, sr, sb, x, y;
		logic [7:0] r, g, b;
		bit row_end;
		w = clamp_dim(pred_width);
		h = clamp_dim(pred_height);
		sr = pred_swap ? int'(p.b0) : int'(p.b2);
		sb = pred_swap ? int'(p.b2) : int'(p.b0);
		r = blend_channel(sr, int'({p.dest[15:11], 3'b000}), int'(p.alpha));
		g = blend_channel(int'(p.b1), int'({p.dest[10:5], 2'b00}), int'(p.alpha));
		b = blend_channel(sb, int'({p.dest[4:0], 3'b000}), int'(p.alpha));
		res.colour = {r[7:3], g[7:2], b[7:3]};
		x = int'(pred_origin_x) + column_count;
		y = int'(pred_origin_y) + h - 1 - row_count;
		res.x = x[bmpab_pkg::COORD_W-1:0];
		res.y = y[bmpab_pkg::COORD_W-1:0];
		row_end = column_count >= w - 1;
		res.last = row_end && (row_count >= h - 1);
		if (res.last) begin
			column_count = 0;
			row_count = 0;
		end else if (row_end) begin
			column_count = 0;
			row_count = row_count + 1;
		end else begin
			column_count = column_count + 1;
		end
		return res;
	endfunction

	// source driver: predicts each accepted transfer and offers the next pending pixel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			src_take = s_tvalid && s_tready;
			if (src_take)
				expected_pixels.push_back(blend_and_place(offered_pixel));
			if (!s_tvalid || src_take) begin
				src_offer = no_idle || ($urandom_range(99) >= IDLE_PCT);
				if (pending_pixels.size() != 0 && src_offer) begin
					offered_pixel = pending_pixels.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered_pixel.dest, offered_pixel.alpha, offered_pixel.b2,
						offered_pixel.b1, offered_pixel.b0};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares each transfer with the oldest expectation, drives m_tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.x = m_tdata[13:0];
				seen.y = m_tdata[27:14];
				seen.colour = m_tdata[43:28];
				seen.last = m_tlast;
				if (expected_pixels.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected pixel: x=%0d y=%0d colour=%h last=%b",
							$signed(seen.x), $signed(seen.y), seen.colour, seen.last);
				end else if (seen != expected_pixels[0]) begin
					error_count++;
					if (error_count <= 10)
						$display({"mismatch: expected x=%0d y=%0d colour=%h last=%b, ",
							"got x=%0d y=%0d colour=%h last=%b"},
							$signed(expected_pixels[0].x), $signed(expected_pixels[0].y),
							expected_pixels[0].colour, expected_pixels[0].last,
							$signed(seen.x), $signed(seen.y), seen.colour, seen.last);
					void'(expected_pixels.pop_front());
				end else begin
					void'(expected_pixels.pop_front());
				end
			end
			// long hold-off so the internal queue fills and the input stalls
			if (stall_served != stall_requests) begin
				stall_served = stall_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL bmp_alpha_blend_rgb565");
				$finish;
			end
		end
	end

	task automatic write_reg(input bmpab_pkg::reg_idx_t idx, input logic [12:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			bmpab_pkg::REG_ORIGIN_X: pred_origin_x = val;
			bmpab_pkg::REG_ORIGIN_Y: pred_origin_y = val;
			bmpab_pkg::REG_WIDTH:    pred_width = val;
			bmpab_pkg::REG_HEIGHT:   pred_height = val;
			bmpab_pkg::REG_SWAP:     pred_swap = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void add_pixel(input logic [7:0] b0, input logic [7:0] b1,
	                                  input logic [7:0] b2, input logic [7:0] a,
	                                  input logic [15:0] dest);
		src_pixel_t p;
		p.b0 = b0;
		p.b1 = b1;
		p.b2 = b2;
		p.alpha = a;
		p.dest = dest;
		pending_pixels.push_back(p);
	endfunction

	function automatic void add_random_pixel();
		int pick;
		logic [7:0] a;
		pick = $urandom_range(99);
		if (pick < 20)
			a = 8'd0;
		else if (pick < 40)
			a = 8'd255;
		else
			a = 8'($urandom);
		add_pixel(8'($urandom), 8'($urandom), 8'($urandom), a, 16'($urandom));
	endfunction

	// mostly small images, sometimes the clamped and largest sizes
	function automatic logic [12:0] random_dim();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return 13'($urandom_range(8, 1));
		if (pick < 80)
			return 13'($urandom_range(64, 9));
		if (pick < 85)
			return 13'd0;
		if (pick < 90)
			return 13'd4096;
		if (pick < 95)
			return 13'd8191;
		return 13'($urandom);
	endfunction

	function automatic logic [12:0] random_origin();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 13'h1000;
		if (pick < 20)
			return 13'h0FFF;
		return 13'($urandom);
	endfunction

	initial begin
		int sent;
		int phase_len;
		int phase;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: every pixel is a whole image, alpha and colour extremes
		@(negedge clk);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
		add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF);
		add_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 16'h0000);
		add_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 16'hFFFF);
		add_pixel(8'h12, 8'h34, 8'hC8, 8'h80, 16'hA5F3);
		wait_idle();

		// most negative origin, zero sizes treated as one, swapped channels
		write_reg(bmpab_pkg::REG_ORIGIN_X, 13'h1000);
		write_reg(bmpab_pkg::REG_ORIGIN_Y, 13'h1000);
		write_reg(bmpab_pkg::REG_WIDTH, 13'd0);
		write_reg(bmpab_pkg::REG_HEIGHT, 13'd0);
		write_reg(bmpab_pkg::REG_SWAP, 13'd1);
		@(negedge clk);
		add_pixel(8'hFF, 8'h80, 8'h00, 8'hFF, 16'h1234);
		add_pixel(8'h00, 8'h80, 8'hFF, 8'h7F, 16'hF81F);
		add_pixel(8'hAA, 8'h55, 8'h0F, 8'h01, 16'h07E0);
		wait_idle();

		// largest origin, a small image walked bottom-up
		write_reg(bmpab_pkg::REG_ORIGIN_X, 13'h0FFF);
		write_reg(bmpab_pkg::REG_ORIGIN_Y, 13'h0FFF);
		write_reg(bmpab_pkg::REG_WIDTH, 13'd4);
		write_reg(bmpab_pkg::REG_HEIGHT, 13'd3);
		write_reg(bmpab_pkg::REG_SWAP, 13'd0);
		@(negedge clk);
		repeat (6) add_random_pixel();
		wait_idle();

		// size shrunk below the counters mid-image: row and image end at once
		write_reg(bmpab_pkg::REG_WIDTH, 13'd2);
		write_reg(bmpab_pkg::REG_HEIGHT, 13'd1);
		@(negedge clk);
		repeat (3) add_random_pixel();
		wait_idle();

		// sizes above the maximum are clamped
		write_reg(bmpab_pkg::REG_WIDTH, 13'd8191);
		write_reg(bmpab_pkg::REG_HEIGHT, 13'd8191);
		@(negedge clk);
		repeat (4) add_random_pixel();
		wait_idle();
		write_reg(bmpab_pkg::REG_WIDTH, 13'd4096);
		write_reg(bmpab_pkg::REG_HEIGHT, 13'd4096);
		@(negedge clk);
		repeat (3) add_random_pixel();
		wait_idle();

		// random phases with fresh settings
		sent = 0;
		phase = 0;
		while (sent < ITEM_TARGET) begin
			write_reg(bmpab_pkg::REG_WIDTH, random_dim());
			write_reg(bmpab_pkg::REG_HEIGHT, random_dim());
			if ($urandom_range(1) == 1)
				write_reg(bmpab_pkg::REG_ORIGIN_X, random_origin());
			if ($urandom_range(1) == 1)
				write_reg(bmpab_pkg::REG_ORIGIN_Y, random_origin());
			if ($urandom_range(1) == 1)
				write_reg(bmpab_pkg::REG_SWAP, 13'($urandom_range(1)));
			phase_len = $urandom_range(140, 60);
			@(negedge clk);
			no_idle = (phase == 2);
			if (phase == 4)
				stall_requests++;
			repeat (phase_len) add_random_pixel();
			sent += phase_len;
			wait_idle();
			no_idle = 1'b0;
			phase++;
		end

		repeat (10) @(posedge clk);
		if (expected_pixels.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("PASS bmp_alpha_blend_rgb565");
		else
			$display("FAIL bmp_alpha_blend_rgb565");
		$finish;
	end

endmodule
`default_nettype wire
